// ===== rtl/lslf_pkg.sv =====
// Shared types and constants for the least-squares line fit core.
// No dependencies; every other file in rtl/ imports this package.
package lslf_pkg;

  // Field widths of the request and response beats.
  localparam int XW     = 16;
  localparam int YW     = 32;
  localparam int OW     = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam int MAX_POINTS_DEF = 1024;

  // Saturation limits of a signed 32-bit integer (Q32.0) result.
  localparam logic signed [OW-1:0] Q_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] Q_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD     = 2'd0,
    KIND_FIT     = 2'd1,
    KIND_PREDICT = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_FLAT = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } state_e;

  // Products formed one after another by the serial multiplier.
  typedef enum logic [2:0] {
    PR_N_SXX,
    PR_SX_SX,
    PR_N_SXY,
    PR_SX_SY,
    PR_SXX_SY,
    PR_SX_SXY
  } prod_e;

endpackage

// ===== rtl/lslf_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on lslf_pkg for the field widths.
interface lslf_in_if import lslf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic signed [XW-1:0]     x_value;
  logic signed [YW-1:0]     y_value;

  modport source (output valid, kind, x_value, y_value, input ready);
  modport sink (input valid, kind, x_value, y_value, output ready);
endinterface

interface lslf_out_if import lslf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic signed [OW-1:0]     slope;
  logic signed [OW-1:0]     intercept;
  logic signed [OW-1:0]     predicted;

  modport source (output valid, status, slope, intercept, predicted, input ready);
  modport sink (input valid, status, slope, intercept, predicted, output ready);
endinterface

// ===== rtl/least_squares_line_fit_core.sv =====
// Least-squares line fit: running sums, serial multiplier and serial divider.
// Depends on lslf_pkg and the channel interfaces in lslf_if.sv.
//
//   channel  dir  beat contents                          handshake
//   req_i    in   kind, x_value, y_value                 valid/ready
//   rsp_o    out  status, slope, intercept, predicted    valid/ready
//
// Add, predict and the unused kind are handled as the request is taken; the
// response sits in the output register from the next cycle on, and a new
// request is taken while it is being drained. A calculate walks six products
// through a shift-add multiplier (one multiplier bit per cycle) and two
// quotients through a restoring divider (one quotient bit per cycle). Too few
// points answers at once, all x equal after the first two products. Reset
// clears the sums and the fit.
// While a calculate runs, or while an undrained response blocks, ready is low.
module least_squares_line_fit_core
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lslf_in_if.sink     req_i,
  lslf_out_if.source  rsp_o
);

  localparam int LOG_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SX_W   = XW + 1 + LOG_W;
  localparam int SY_W   = YW + LOG_W;
  localparam int SXY_W  = XW + YW + LOG_W;
  localparam int SXX_W  = 2 * XW - 1 + LOG_W;
  localparam int A_W    = SXY_W;
  localparam int B_W    = SY_W;
  localparam int NUM_W  = A_W + B_W + 1;
  localparam int D_W    = CNT_W + SXX_W;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int PW     = XW + YW;

  localparam logic [OW+1:0] NEG_LIM = (OW + 2)'(1) << (OW - 1);

  // Architectural state. The sum of squares never goes negative, so it is
  // kept unsigned to use its top bit.
  logic        [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [SX_W-1:0]  sx_q, sx_d;
  logic signed [SY_W-1:0]  sy_q, sy_d;
  logic signed [SXY_W-1:0] sxy_q, sxy_d;
  logic        [SXX_W-1:0] sxx_q, sxx_d;
  logic signed [OW-1:0]    slope_q, slope_d;
  logic signed [OW-1:0]    icpt_q, icpt_d;
  logic                    fit_ok_q, fit_ok_d;

  // Sequencer.
  state_e                  state_q, state_d;
  prod_e                   prod_q, prod_d;
  logic        [STEP_W-1:0] step_q, step_d;

  // Serial multiplier and divider datapath.
  logic signed [A_W:0]     hi_q, hi_d;
  logic        [B_W-1:0]   lo_q, lo_d;
  logic signed [NUM_W-1:0] acc_q, acc_d;
  logic        [D_W-1:0]   den_q, den_d;
  logic        [D_W-1:0]   rem_q, rem_d;
  logic        [OW:0]      quo_q, quo_d;
  logic                    ovf_q, ovf_d;
  logic                    neg_q, neg_d;

  // Output register.
  logic                    out_vld_q, out_vld_d;
  status_e                 out_stat_q, out_stat_d;
  logic signed [OW-1:0]    out_slope_q, out_slope_d;
  logic signed [OW-1:0]    out_icpt_q, out_icpt_d;
  logic signed [OW-1:0]    out_pred_q, out_pred_d;

  logic                    in_fire;
  logic signed [YW-1:0]    mul_y;
  logic signed [PW-1:0]    xy;
  logic signed [2*XW-1:0]  xx;
  logic signed [PW:0]      pred_sum;
  logic        [PW-OW+1:0] pred_top;
  logic signed [OW-1:0]    pred_res;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [A_W:0]     a_ext;
  logic signed [A_W:0]     addend;
  logic signed [A_W:0]     psum;
  logic signed [NUM_W-1:0] prod_full;
  logic signed [NUM_W-1:0] diff;
  logic                    den_bad;
  logic                    mul_last;

  logic        [D_W:0]     r2;
  logic        [D_W:0]     rsub;
  logic                    ge;
  logic                    div_last;
  logic        [OW+1:0]    rnd;
  logic signed [OW-1:0]    fin_res;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE) && (!out_vld_q || rsp_o.ready);

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_stat_q;
  assign rsp_o.slope     = out_slope_q;
  assign rsp_o.intercept = out_icpt_q;
  assign rsp_o.predicted = out_pred_q;

  // One short multiplier serves both x*y on an add and slope*x on a predict.
  assign mul_y    = (req_i.kind == KIND_ADD) ? req_i.y_value : slope_q;
  assign xy       = req_i.x_value * mul_y;
  assign xx       = req_i.x_value * req_i.x_value;
  assign pred_sum = xy + icpt_q;
  assign pred_top = pred_sum[PW:OW-1];

  always_comb begin
    if ((&pred_top) || !(|pred_top)) begin
      pred_res = pred_sum[OW-1:0];
    end else if (pred_sum[PW]) begin
      pred_res = Q_MIN;
    end else begin
      pred_res = Q_MAX;
    end
  end

  // Operands of the current product; the sums stay still during a calculate.
  always_comb begin
    case (prod_q)
      PR_N_SXX: begin
        mul_a = A_W'(sxx_q);
        mul_b = B_W'({1'b0, cnt_q});
      end
      PR_SX_SX: begin
        mul_a = A_W'(sx_q);
        mul_b = B_W'(sx_q);
      end
      PR_N_SXY: begin
        mul_a = sxy_q;
        mul_b = B_W'({1'b0, cnt_q});
      end
      PR_SX_SY: begin
        mul_a = A_W'(sy_q);
        mul_b = B_W'(sx_q);
      end
      PR_SXX_SY: begin
        mul_a = A_W'(sxx_q);
        mul_b = sy_q;
      end
      PR_SX_SXY: begin
        mul_a = sxy_q;
        mul_b = B_W'(sx_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shift-add step; the multiplier's sign bit carries negative weight, so the
  // last step subtracts the multiplicand.
  assign mul_last  = (step_q == STEP_W'(B_W - 1));
  assign a_ext     = (A_W + 1)'(mul_a);
  assign addend    = lo_q[0] ? (mul_last ? -a_ext : a_ext) : '0;
  assign psum      = hi_q + addend;
  assign prod_full = {psum[A_W], psum, lo_q[B_W-1:1]};
  assign diff      = acc_q - prod_full;
  assign den_bad   = diff[NUM_W-1] || (diff == '0);

  // Restoring division step on the magnitude shifted out of acc_q.
  assign div_last = (step_q == STEP_W'(NUM_W - 1));
  assign r2       = {rem_q, acc_q[NUM_W-1]};
  assign rsub     = r2 - {1'b0, den_q};
  assign ge       = (r2 >= {1'b0, den_q});

  // Floor rounding: a negative quotient with a remainder moves one further down.
  assign rnd = {1'b0, quo_q} + (OW + 2)'(rem_q != '0);

  always_comb begin
    if (neg_q) begin
      if (ovf_q || (rnd > NEG_LIM)) begin
        fin_res = Q_MIN;
      end else begin
        fin_res = -rnd[OW-1:0];
      end
    end else begin
      if (ovf_q || quo_q[OW] || quo_q[OW-1]) begin
        fin_res = Q_MAX;
      end else begin
        fin_res = quo_q[OW-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (req_i.kind == KIND_FIT) && (cnt_q >= CNT_W'(2))) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          case (prod_q)
            PR_SX_SX:  state_d = den_bad ? ST_IDLE : ST_LOAD;
            PR_SX_SY:  state_d = ST_ABS;
            PR_SX_SXY: state_d = ST_ABS;
            default:   state_d = ST_LOAD;
          endcase
        end
      end
      ST_ABS: state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = (prod_q == PR_SX_SY) ? ST_LOAD : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    cnt_d       = cnt_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    sxx_d       = sxx_q;
    slope_d     = slope_q;
    icpt_d      = icpt_q;
    fit_ok_d    = fit_ok_q;
    prod_d      = prod_q;
    step_d      = step_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    acc_d       = acc_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_slope_d = out_slope_q;
    out_icpt_d  = out_icpt_q;
    out_pred_d  = out_pred_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_vld_d   = 1'b1;
          out_stat_d  = STAT_OK;
          out_slope_d = '0;
          out_icpt_d  = '0;
          out_pred_d  = '0;
          case (req_i.kind)
            KIND_ADD: begin
              if (cnt_q >= CNT_W'(MAX_POINTS)) begin
                out_stat_d = STAT_FULL;
              end else begin
                cnt_d    = cnt_q + CNT_W'(1);
                sx_d     = sx_q + SX_W'(req_i.x_value);
                sy_d     = sy_q + SY_W'(req_i.y_value);
                sxy_d    = sxy_q + SXY_W'(xy);
                sxx_d    = sxx_q + SXX_W'(xx);
                fit_ok_d = 1'b0;
              end
            end
            KIND_FIT: begin
              if (cnt_q < CNT_W'(2)) begin
                out_stat_d = STAT_FEW;
              end else begin
                out_vld_d = 1'b0;
                prod_d    = PR_N_SXX;
              end
            end
            KIND_PREDICT: begin
              if (fit_ok_q) begin
                out_pred_d = pred_res;
              end else begin
                out_stat_d = STAT_FEW;
              end
            end
            default: begin
              out_stat_d = STAT_OK;
            end
          endcase
        end
      end
      ST_LOAD: begin
        hi_d   = '0;
        lo_d   = mul_b;
        step_d = '0;
      end
      ST_MUL: begin
        hi_d   = prod_full[NUM_W-1:B_W];
        lo_d   = prod_full[B_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (mul_last) begin
          case (prod_q)
            PR_N_SXX: begin
              acc_d  = prod_full;
              prod_d = PR_SX_SX;
            end
            PR_SX_SX: begin
              den_d  = diff[D_W-1:0];
              prod_d = PR_N_SXY;
              if (den_bad) begin
                out_vld_d   = 1'b1;
                out_stat_d  = STAT_FLAT;
                out_slope_d = '0;
                out_icpt_d  = '0;
                out_pred_d  = '0;
              end
            end
            PR_N_SXY: begin
              acc_d  = prod_full;
              prod_d = PR_SX_SY;
            end
            PR_SXX_SY: begin
              acc_d  = prod_full;
              prod_d = PR_SX_SXY;
            end
            default: begin
              acc_d = diff;
            end
          endcase
        end
      end
      ST_ABS: begin
        neg_d  = acc_q[NUM_W-1];
        acc_d  = acc_q[NUM_W-1] ? -acc_q : acc_q;
        rem_d  = '0;
        quo_d  = '0;
        ovf_d  = 1'b0;
        step_d = '0;
      end
      ST_DIV: begin
        acc_d  = acc_q <<< 1;
        rem_d  = ge ? rsub[D_W-1:0] : r2[D_W-1:0];
        quo_d  = {quo_q[OW-1:0], ge};
        ovf_d  = ovf_q || quo_q[OW];
        step_d = step_q + STEP_W'(1);
      end
      ST_FIN: begin
        if (prod_q == PR_SX_SY) begin
          slope_d = fin_res;
          prod_d  = PR_SXX_SY;
        end else begin
          icpt_d      = fin_res;
          fit_ok_d    = 1'b1;
          out_vld_d   = 1'b1;
          out_stat_d  = STAT_OK;
          out_slope_d = slope_q;
          out_icpt_d  = fin_res;
          out_pred_d  = '0;
        end
      end
      default: begin
        out_vld_d = out_vld_q && !rsp_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxy_q     <= '0;
      sxx_q     <= '0;
      slope_q   <= '0;
      icpt_q    <= '0;
      fit_ok_q  <= 1'b0;
      state_q   <= ST_IDLE;
      prod_q    <= PR_N_SXX;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sxy_q     <= sxy_d;
      sxx_q     <= sxx_d;
      slope_q   <= slope_d;
      icpt_q    <= icpt_d;
      fit_ok_q  <= fit_ok_d;
      state_q   <= state_d;
      prod_q    <= prod_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    acc_q       <= acc_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    ovf_q       <= ovf_d;
    neg_q       <= neg_d;
    out_stat_q  <= out_stat_d;
    out_slope_q <= out_slope_d;
    out_icpt_q  <= out_icpt_d;
    out_pred_q  <= out_pred_d;
  end

  // A calculate in flight must hold off new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_i.ready)
    else $error("request taken while a calculate is in flight");

  // The divider keeps its partial remainder below a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((den_q != '0) && (rem_q < den_q)))
    else $error("divider remainder out of range");

  // A new fit always comes with a successful response beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fit_ok_q) |-> (rsp_o.valid && (rsp_o.status == STAT_OK)))
    else $error("fit marked valid without a response");

  // The point count never passes the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

endmodule
